/* sv/assert_macros.svh */
// Concurrent assertion helpers, sampled on the rising clock edge.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while reset is low.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked during reset as well.
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

/* sv/dqmc_pkg.sv */
`timescale 1ns / 1ps

package dqmc_pkg;

   localparam int FUNC_W   = 3;
   localparam int VALUE_W  = 32;
   localparam int FILL_W   = 7;
   localparam int STATUS_W = 2;

   localparam logic [FUNC_W-1:0] FUNC_PUSH_FRONT = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_PUSH_BACK  = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_POP_FRONT  = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_POP_BACK   = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_COUNT      = 3'd4;
   localparam logic [FUNC_W-1:0] FUNC_PURGE      = 3'd5;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_POP_EMPTY = 2'd2;

   typedef struct packed {
      logic [FUNC_W-1:0]  func;
      logic [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [VALUE_W-1:0]  front_value;
      logic [VALUE_W-1:0]  back_value;
      logic [FILL_W-1:0]   fill;
      logic                is_empty;
      logic [FILL_W-1:0]   match_count;
      logic [STATUS_W-1:0] status;
   } rsp_type;

endpackage

/* sv/deque_with_match_count_and_purge.sv */
`timescale 1ns / 1ps
// Channel  Ports              Word                 Direction
// request  req_valid/ready    dqmc_pkg::req_type   in
// result   rsp_valid/ready    dqmc_pkg::rsp_type   out
//
// One request at a time; req_ready is high only while idle.
// Push, pop and unused codes: steps S_EXEC, S_RDF, S_RDB, S_RDE, S_OUT from accept to
// result load (S_RDB and S_RDE skipped if the queue ends empty), reading front and
// back through the one store port. Count and purge add S_SCAN after S_EXEC, one
// stored entry read per cycle.
// Reset is synchronous; the store holds no reset and needs no clearing pass.
// A result held by a stalled receiver keeps the block in its last step.

module deque_with_match_count_and_purge #(
   parameter int CAPACITY   = 64,
   parameter int ITEM_WIDTH = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  dqmc_pkg::req_type req_word,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output dqmc_pkg::rsp_type rsp_word
);

   localparam int PW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);

   typedef enum logic [6:0] {
      S_IDLE = 7'b0000001,
      S_EXEC = 7'b0000010,
      S_SCAN = 7'b0000100,
      S_RDF  = 7'b0001000,
      S_RDB  = 7'b0010000,
      S_RDE  = 7'b0100000,
      S_OUT  = 7'b1000000
   } state_type;

   state_type                         state_ff, state_in;
   logic [PW-1:0]                     fp_ff, fp_in;
   logic [CW-1:0]                     total_ff, total_in;
   logic [CW-1:0]                     idx_ff, idx_in;
   logic [CW-1:0]                     kept_ff, kept_in;
   logic [CW-1:0]                     match_ff, match_in;
   logic                              pend_ff, pend_in;
   logic [dqmc_pkg::FUNC_W-1:0]       func_ff, func_in;
   logic [ITEM_WIDTH-1:0]             key_ff, key_in;
   logic [dqmc_pkg::STATUS_W-1:0]     status_ff, status_in;
   logic [dqmc_pkg::VALUE_W-1:0]      front_ff, front_in;
   logic [dqmc_pkg::VALUE_W-1:0]      back_ff, back_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   dqmc_pkg::rsp_type                 rsp_ff, rsp_in;

   logic                  wr_en;
   logic [PW-1:0]         wr_addr;
   logic [ITEM_WIDTH-1:0] wr_data;
   logic [PW-1:0]         rd_addr;
   logic [ITEM_WIDTH-1:0] rd_data;

   logic          full;
   logic          empty;
   logic          issue;
   logic [PW-1:0] fp_dec;
   logic [PW-1:0] fp_inc;

   function automatic logic [PW-1:0] slot(input logic [PW-1:0] base,
                                          input logic [CW-1:0] off);
      logic [CW:0] sum;
      sum = (CW+1)'(base) + (CW+1)'(off);
      if (sum >= (CW+1)'(CAPACITY)) begin
         sum = sum - (CW+1)'(CAPACITY);
      end
      return sum[PW-1:0];
   endfunction

   function automatic logic [dqmc_pkg::VALUE_W-1:0] to_word(input logic [ITEM_WIDTH-1:0] v);
      logic [63:0] wide;
      wide = 64'(v);
      return wide[dqmc_pkg::VALUE_W-1:0];
   endfunction

   dqmc_store #(
      .DEPTH (CAPACITY),
      .WIDTH (ITEM_WIDTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign full   = (total_ff == CW'(CAPACITY));
   assign empty  = (total_ff == '0);
   assign issue  = (idx_ff < total_ff);
   assign fp_dec = (fp_ff == '0) ? PW'(CAPACITY - 1) : fp_ff - PW'(1);
   assign fp_inc = (fp_ff == PW'(CAPACITY - 1)) ? '0 : fp_ff + PW'(1);

   always_comb begin
      state_in     = state_ff;
      fp_in        = fp_ff;
      total_in     = total_ff;
      idx_in       = idx_ff;
      kept_in      = kept_ff;
      match_in     = match_ff;
      pend_in      = pend_ff;
      func_in      = func_ff;
      key_in       = key_ff;
      status_in    = status_ff;
      front_in     = front_ff;
      back_in      = back_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      wr_en        = 1'b0;
      wr_addr      = slot(fp_ff, kept_ff);
      wr_data      = rd_data;
      rd_addr      = slot(fp_ff, idx_ff);

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               func_in   = req_word.func;
               key_in    = ITEM_WIDTH'(req_word.value);
               status_in = dqmc_pkg::STATUS_OK;
               match_in  = '0;
               state_in  = S_EXEC;
            end
         end
         S_EXEC: begin
            idx_in   = '0;
            kept_in  = '0;
            pend_in  = 1'b0;
            state_in = S_RDF;
            unique case (func_ff)
               dqmc_pkg::FUNC_PUSH_FRONT: begin
                  if (full) begin
                     status_in = dqmc_pkg::STATUS_FULL;
                  end else begin
                     wr_en    = 1'b1;
                     wr_addr  = fp_dec;
                     wr_data  = key_ff;
                     fp_in    = fp_dec;
                     total_in = total_ff + CW'(1);
                  end
               end
               dqmc_pkg::FUNC_PUSH_BACK: begin
                  if (full) begin
                     status_in = dqmc_pkg::STATUS_FULL;
                  end else begin
                     wr_en    = 1'b1;
                     wr_addr  = slot(fp_ff, total_ff);
                     wr_data  = key_ff;
                     total_in = total_ff + CW'(1);
                  end
               end
               dqmc_pkg::FUNC_POP_FRONT: begin
                  if (empty) begin
                     status_in = dqmc_pkg::STATUS_POP_EMPTY;
                  end else begin
                     fp_in    = fp_inc;
                     total_in = total_ff - CW'(1);
                  end
               end
               dqmc_pkg::FUNC_POP_BACK: begin
                  if (empty) begin
                     status_in = dqmc_pkg::STATUS_POP_EMPTY;
                  end else begin
                     total_in = total_ff - CW'(1);
                  end
               end
               dqmc_pkg::FUNC_COUNT, dqmc_pkg::FUNC_PURGE: begin
                  state_in = S_SCAN;
               end
               default: begin
               end
            endcase
         end
         S_SCAN: begin
            // read entry idx while comparing the one read last cycle
            rd_addr = slot(fp_ff, idx_ff);
            pend_in = issue;
            if (issue) begin
               idx_in = idx_ff + CW'(1);
            end
            if (pend_ff) begin
               if (rd_data == key_ff) begin
                  match_in = match_ff + CW'(1);
               end else begin
                  kept_in = kept_ff + CW'(1);
                  if (func_ff == dqmc_pkg::FUNC_PURGE) begin
                     wr_en   = 1'b1;
                     wr_addr = slot(fp_ff, kept_ff);
                     wr_data = rd_data;
                  end
               end
            end
            if (!issue && !pend_ff) begin
               if (func_ff == dqmc_pkg::FUNC_PURGE) begin
                  total_in = kept_ff;
                  if (kept_ff == '0) begin
                     fp_in = '0;
                  end
               end
               state_in = S_RDF;
            end
         end
         S_RDF: begin
            rd_addr = slot(fp_ff, '0);
            if (empty) begin
               front_in = '0;
               back_in  = '0;
               state_in = S_OUT;
            end else begin
               state_in = S_RDB;
            end
         end
         S_RDB: begin
            front_in = to_word(rd_data);
            rd_addr  = slot(fp_ff, total_ff - CW'(1));
            state_in = S_RDE;
         end
         S_RDE: begin
            back_in  = to_word(rd_data);
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.front_value = front_ff;
               rsp_in.back_value  = back_ff;
               rsp_in.fill        = dqmc_pkg::FILL_W'(total_ff);
               rsp_in.is_empty    = empty;
               rsp_in.match_count = dqmc_pkg::FILL_W'(match_ff);
               rsp_in.status      = status_ff;
               rsp_valid_in       = 1'b1;
               state_in           = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fp_ff        <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fp_ff        <= fp_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff    <= idx_in;
      kept_ff   <= kept_in;
      match_ff  <= match_in;
      pend_ff   <= pend_in;
      func_ff   <= func_in;
      key_ff    <= key_in;
      status_ff <= status_in;
      front_ff  <= front_in;
      back_ff   <= back_in;
      rsp_ff    <= rsp_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

endmodule

/* sv/dqmc_store.sv */
`timescale 1ns / 1ps

module dqmc_store #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/dqmc_checker.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dqmc_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input dqmc_pkg::rsp_type rsp_word
);

   `ASSERT_CLK(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word), "result word dropped or changed while stalled")
   `ASSERT_CLK(a_busy_after_accept, req_valid && req_ready |=> !req_ready, "new word taken while busy")
   `ASSERT_CLK(a_empty_zeros, rsp_valid && rsp_word.is_empty |-> rsp_word.front_value == '0 && rsp_word.back_value == '0 && rsp_word.fill == '0, "empty result with stale contents")
   `ASSERT_CLK(a_full_refusal, rsp_valid && rsp_word.status == dqmc_pkg::STATUS_FULL |-> !rsp_word.is_empty && rsp_word.match_count == '0, "full refusal on a non-full queue")
   `ASSERT_CLK(a_pop_refusal, rsp_valid && rsp_word.status == dqmc_pkg::STATUS_POP_EMPTY |-> rsp_word.is_empty && rsp_word.match_count == '0, "pop refusal on a non-empty queue")

endmodule

bind deque_with_match_count_and_purge dqmc_checker u_dqmc_checker (.*);

/* tb/deque_shadow.sv */
`timescale 1ns / 1ps

module deque_shadow
   import dqmc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_ready,
   input  req_type req_word,
   input  logic    rsp_valid,
   input  logic    rsp_ready,
   input  rsp_type rsp_word,
   output int      awaited_count,
   output int      mismatch_total
);

   localparam int DEPTH = 64;

   logic [VALUE_W-1:0] cells [DEPTH];
   logic [5:0]         head;
   logic [FILL_W-1:0]  total;
   rsp_type            awaited_views [$];
   int                 result_index;

   function automatic logic [5:0] slot(input logic [FILL_W-1:0] offset);
      return head + offset[5:0];
   endfunction

   // Applies one request word to the shadow deque and returns the view after it.
   function automatic rsp_type after_request(input req_type rq);
      rsp_type           view;
      logic [FILL_W-1:0] hits;
      logic [FILL_W-1:0] kept;
      logic [FILL_W-1:0] start;
      logic [VALUE_W-1:0] v;
      view = '0;
      hits = '0;
      view.status = STATUS_OK;
      case (rq.func)
         FUNC_PUSH_FRONT: begin
            if (total == DEPTH) begin
               view.status = STATUS_FULL;
            end else begin
               head = head - 1'b1;
               cells[head] = rq.value;
               total = total + 1'b1;
            end
         end
         FUNC_PUSH_BACK: begin
            if (total == DEPTH) begin
               view.status = STATUS_FULL;
            end else begin
               cells[slot(total)] = rq.value;
               total = total + 1'b1;
            end
         end
         FUNC_POP_FRONT: begin
            if (total == 0) begin
               view.status = STATUS_POP_EMPTY;
            end else begin
               head = head + 1'b1;
               total = total - 1'b1;
            end
         end
         FUNC_POP_BACK: begin
            if (total == 0) begin
               view.status = STATUS_POP_EMPTY;
            end else begin
               total = total - 1'b1;
            end
         end
         FUNC_COUNT: begin
            for (int i = 0; i < total; i++) begin
               if (cells[slot(FILL_W'(i))] == rq.value) hits = hits + 1'b1;
            end
         end
         FUNC_PURGE: begin
            start = total;
            kept = '0;
            for (int i = 0; i < start; i++) begin
               v = cells[slot(FILL_W'(i))];
               if (v != rq.value) begin
                  cells[slot(kept)] = v;
                  kept = kept + 1'b1;
               end
            end
            hits = start - kept;
            total = kept;
            if (kept == 0) head = '0;
         end
         default: ;
      endcase
      if (total != 0) begin
         view.front_value = cells[slot('0)];
         view.back_value  = cells[slot(total - 1'b1)];
      end
      view.fill        = total;
      view.is_empty    = (total == 0);
      view.match_count = hits;
      return view;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      logic    bad;
      if (reset) begin
         head = '0;
         total = '0;
         awaited_views.delete();
         awaited_count = 0;
         mismatch_total = 0;
         result_index = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (awaited_views.size() == 0) begin
               mismatch_total++;
               if (mismatch_total <= 10)
                  $display("result %0d: unexpected word %h", result_index, rsp_word);
            end else begin
               want = awaited_views.pop_front();
               bad = (rsp_word.front_value !== want.front_value)
                  || (rsp_word.back_value !== want.back_value)
                  || (rsp_word.fill !== want.fill)
                  || (rsp_word.is_empty !== want.is_empty)
                  || (rsp_word.match_count !== want.match_count)
                  || (rsp_word.status !== want.status);
               if (bad) begin
                  mismatch_total++;
                  if (mismatch_total <= 10) begin
                     $display("result %0d: want front=%h back=%h fill=%0d empty=%b hits=%0d st=%0d",
                        result_index, want.front_value, want.back_value, want.fill,
                        want.is_empty, want.match_count, want.status);
                     $display("result %0d:  got front=%h back=%h fill=%0d empty=%b hits=%0d st=%0d",
                        result_index, rsp_word.front_value, rsp_word.back_value, rsp_word.fill,
                        rsp_word.is_empty, rsp_word.match_count, rsp_word.status);
                  end
               end
            end
            result_index++;
         end
         if (req_valid && req_ready) awaited_views.push_back(after_request(req_word));
         awaited_count = awaited_views.size();
      end
   end

endmodule

/* tb/tb_deque_with_match_count_and_purge.sv */
`timescale 1ns / 1ps

module tb_deque_with_match_count_and_purge;
   import dqmc_pkg::*;

   localparam logic [FUNC_W-1:0] FUNC_SPARE_LO = 3'd6;
   localparam logic [FUNC_W-1:0] FUNC_SPARE_HI = 3'd7;
   localparam int RANDOM_WORDS   = 950;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int SETTLE_CYCLES  = 20;

   typedef enum int {MODE_GROW, MODE_SHRINK, MODE_MIXED, MODE_HOTKEY} mix_mode_type;

   // cumulative percentages: push front, push back, pop front, pop back, count, purge
   localparam int CUTS [4][6] = '{
      '{40, 86, 89, 92, 96, 97},
      '{5, 10, 50, 88, 93, 97},
      '{18, 36, 52, 68, 82, 96},
      '{35, 75, 78, 81, 91, 96}
   };
   localparam logic [FUNC_W-1:0] OP_ORDER [6] = '{
      FUNC_PUSH_FRONT, FUNC_PUSH_BACK, FUNC_POP_FRONT, FUNC_POP_BACK, FUNC_COUNT, FUNC_PURGE
   };

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_word;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_word;
   int      awaited_count;
   int      mismatch_total;
   int      quiet_cycles;
   int      stall_left;
   bit      send_gaps;
   bit      recv_gaps;

   deque_with_match_count_and_purge uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

   deque_shadow shadow (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_word       (req_word),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_word       (rsp_word),
      .awaited_count  (awaited_count),
      .mismatch_total (mismatch_total)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int pick_gap();
      if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   initial begin
      rsp_ready = 1'b0;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
            if (recv_gaps && $urandom_range(0, 3) == 0) stall_left = pick_gap();
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   task automatic send_word(input req_type w);
      int gap;
      gap = (send_gaps && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (awaited_count != 0) @(negedge clock);
   endtask

   initial begin
      mix_mode_type       mode;
      int                 sent;
      int                 seg;
      int                 seg_len;
      int                 r;
      int                 pick;
      logic [FUNC_W-1:0]  func;
      logic [VALUE_W-1:0] value;
      logic [VALUE_W-1:0] hot_key;
      req_valid = 1'b0;
      req_word = '0;
      reset = 1'b1;
      send_gaps = 1'b0;
      recv_gaps = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty-queue corners, spare codes, extremes, purge of keys at the front
      send_word('{func: FUNC_POP_FRONT, value: '0});
      send_word('{func: FUNC_POP_BACK, value: '1});
      send_word('{func: FUNC_COUNT, value: '0});
      send_word('{func: FUNC_PURGE, value: 32'h5});
      send_word('{func: FUNC_SPARE_LO, value: 32'h1234_5678});
      send_word('{func: FUNC_SPARE_HI, value: '1});
      send_word('{func: FUNC_PUSH_BACK, value: '0});
      send_word('{func: FUNC_PUSH_FRONT, value: '1});
      send_word('{func: FUNC_PUSH_FRONT, value: 32'hA5});
      send_word('{func: FUNC_PUSH_BACK, value: 32'hA5});
      send_word('{func: FUNC_PUSH_FRONT, value: 32'hA5});
      send_word('{func: FUNC_COUNT, value: 32'hA5});
      send_word('{func: FUNC_SPARE_LO, value: '0});
      send_word('{func: FUNC_PURGE, value: 32'hA5});
      send_word('{func: FUNC_POP_BACK, value: '0});
      send_word('{func: FUNC_POP_FRONT, value: '0});
      send_word('{func: FUNC_PUSH_BACK, value: 32'h7});
      send_word('{func: FUNC_PURGE, value: 32'h7});
      send_word('{func: FUNC_PUSH_BACK, value: 32'h1});
      send_word('{func: FUNC_PUSH_FRONT, value: 32'h2});
      send_word('{func: FUNC_PURGE, value: 32'h2});
      send_word('{func: FUNC_COUNT, value: 32'h1});
      send_word('{func: FUNC_SPARE_HI, value: 32'h8000_0000});
      drain_results();

      sent = 0;
      seg = 0;
      while (sent < RANDOM_WORDS) begin
         if (seg == 2 || seg == 3) begin
            mode = MODE_GROW;
            seg_len = 100;
         end else if (seg == 4) begin
            mode = MODE_SHRINK;
            seg_len = 100;
         end else begin
            mode = mix_mode_type'($urandom_range(0, 3));
            seg_len = $urandom_range(30, 110);
         end
         hot_key = $urandom;
         send_gaps = ($urandom_range(0, 3) != 0);
         recv_gaps = ($urandom_range(0, 3) != 0);
         for (int n = 0; n < seg_len && sent < RANDOM_WORDS; n++) begin
            r = $urandom_range(0, 99);
            func = r[0] ? FUNC_SPARE_HI : FUNC_SPARE_LO;
            for (int k = 5; k >= 0; k--) begin
               if (r < CUTS[mode][k]) func = OP_ORDER[k];
            end
            pick = $urandom_range(0, 9);
            if (mode == MODE_HOTKEY && pick < 7) value = hot_key;
            else if (pick < 5) value = VALUE_W'(pick);
            else if (pick == 5) value = '1;
            else value = $urandom;
            send_word('{func: func, value: value});
            sent++;
         end
         if ($urandom_range(0, 3) == 0) drain_results();
         seg++;
      end

      drain_results();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (mismatch_total == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
